FILE: design/psc_pkg.sv
package psc_pkg;

    // Table and block geometry
    localparam int TABLE_ENTRIES = 64;
    localparam int MAX_BLOCK     = 4;
    localparam int BLK_W         = 8 * MAX_BLOCK;
    localparam int CNT_W         = $clog2(MAX_BLOCK + 1);
    localparam int LEN_W         = 3;

    // Input item kinds (carried on tuser)
    localparam logic [1:0] MODE_TEXT  = 2'd0;
    localparam logic [1:0] MODE_FLUSH = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;

    // Configuration register indexes
    localparam logic CFG_DIRECTION = 1'b0;
    localparam logic CFG_BLOCK_LEN = 1'b1;

    // One table slot as written from the input stream
    typedef struct packed {
        logic [BLK_W-1:0] plain;
        logic [BLK_W-1:0] cipher;
        logic [LEN_W-1:0] len;
        logic             valid;
    } t_entry;

    // Lookup token that walks down the row of slot cells
    typedef struct packed {
        logic             vld;
        logic [BLK_W-1:0] blk;
        logic [CNT_W-1:0] n;
        logic             found;
        logic [BLK_W-1:0] res;
    } t_tok;

    // Keep the low n bytes of a block
    function automatic logic [BLK_W-1:0] byte_mask(input logic [CNT_W-1:0] n);
        logic [BLK_W-1:0] m;
        m = '0;
        for (int k = 0; k < MAX_BLOCK; k++) begin
            if (CNT_W'(k) < n) begin
                m[8*k +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

FILE: design/polygram_substitution_cipher.sv
// Channel   Dir  Handshake                       Payload
// s_axis    in   s_axis_tvalid / s_axis_tready    tdata: byte, slot, plain, cipher, len, valid
//                                                 tuser: mode
// m_axis    out  m_axis_tvalid / m_axis_tready    tdata: out_byte, tlast: last_of_run
// cfg       in   i_cfg_we                         i_cfg_idx, i_cfg_data
//
// A text byte that does not complete a block, a flush of an empty block and a
// table write leave the block idle. A completed block walks the row of slot
// cells one cell per cycle, then goes out one byte per cycle on m_axis while
// m_axis_tready is high; the block then returns to idle. m_axis stalls extend
// the run byte for byte. Synchronous active-low reset clears the slot valid
// marks, the gather state and the registers to direction 0, block_len 3.
module polygram_substitution_cipher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,   // data_byte[7:0], entry_index[13:8],
                                        // entry_plain[45:14], entry_cipher[77:46],
                                        // entry_length[80:78], entry_valid[81], zeros
    input  logic [1:0]  s_axis_tuser,   // mode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // out_byte[7:0]
    output logic        m_axis_tlast,   // last_of_run
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [2:0]  i_cfg_data
);
    import psc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_EMIT   = 3'b100
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic             r_direction;
    logic [2:0]       r_block_len;
    logic [BLK_W-1:0] r_buf;
    logic [BLK_W-1:0] n_buf;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    logic             w_acc;
    logic [1:0]       w_mode;
    logic [7:0]       w_byte;
    logic [5:0]       w_slot;
    t_entry           w_entry;
    logic [CNT_W-1:0] w_eff;
    logic [BLK_W-1:0] w_gbuf;
    logic [CNT_W-1:0] w_gcnt;
    logic             w_start;
    logic             w_ser_busy;
    logic             w_load;
    logic [BLK_W-1:0] w_res;
    t_tok             w_launch;

    t_tok                     w_tok [TABLE_ENTRIES+1];
    logic [TABLE_ENTRIES-1:0] w_tok_vld;

    // Unpack the input transaction
    assign w_acc          = s_axis_tvalid && s_axis_tready;
    assign w_mode         = s_axis_tuser;
    assign w_byte         = s_axis_tdata[7:0];
    assign w_slot         = s_axis_tdata[13:8];
    assign w_entry.plain  = s_axis_tdata[45:14];
    assign w_entry.cipher = s_axis_tdata[77:46];
    assign w_entry.len    = s_axis_tdata[80:78];
    assign w_entry.valid  = s_axis_tdata[81];

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= 1'b0;
            r_block_len <= 3'd3;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DIRECTION: r_direction <= i_cfg_data[0];
                CFG_BLOCK_LEN: r_block_len <= i_cfg_data;
                default:       r_direction <= r_direction;
            endcase
        end
    end

    // Block length clamped to 1..MAX_BLOCK
    always_comb begin
        if (r_block_len == 3'd0) begin
            w_eff = CNT_W'(1);
        end else if (32'(r_block_len) > MAX_BLOCK) begin
            w_eff = CNT_W'(MAX_BLOCK);
        end else begin
            w_eff = CNT_W'(r_block_len);
        end
    end

    // Byte added at the gather position
    always_comb begin
        w_gbuf = r_buf;
        w_gcnt = r_cnt;
        if (32'(r_cnt) < MAX_BLOCK) begin
            for (int k = 0; k < MAX_BLOCK; k++) begin
                if (r_cnt == CNT_W'(k)) begin
                    w_gbuf[8*k +: 8] = w_byte;
                end
            end
            w_gcnt = r_cnt + CNT_W'(1);
        end
    end

    // Gather control and lookup launch
    always_comb begin
        n_buf   = r_buf;
        n_cnt   = r_cnt;
        w_start = 1'b0;
        w_launch.blk   = r_buf;
        w_launch.n     = r_cnt;
        w_launch.found = 1'b0;
        w_launch.res   = '0;
        if (w_acc) begin
            case (w_mode)
                MODE_TEXT: begin
                    if (w_gcnt >= w_eff) begin
                        w_start      = 1'b1;
                        w_launch.blk = w_gbuf;
                        w_launch.n   = w_gcnt;
                        n_buf        = '0;
                        n_cnt        = '0;
                    end else begin
                        n_buf = w_gbuf;
                        n_cnt = w_gcnt;
                    end
                end
                MODE_FLUSH: begin
                    if (r_cnt != '0) begin
                        w_start = 1'b1;
                        n_buf   = '0;
                        n_cnt   = '0;
                    end
                end
                default: ;
            endcase
        end
        w_launch.vld = w_start;
    end

    assign w_tok[0] = w_launch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf <= '0;
            r_cnt <= '0;
        end else begin
            r_buf <= n_buf;
            r_cnt <= n_cnt;
        end
    end

    // Row of slot cells
    for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
        logic w_wr_en;
        assign w_wr_en = w_acc && (w_mode == MODE_WRITE) && (32'(w_slot) == 32'(i));
        psc_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_direction (r_direction),
            .i_wr_en     (w_wr_en),
            .i_wr        (w_entry),
            .i_tok       (w_tok[i]),
            .o_tok       (w_tok[i+1])
        );
        assign w_tok_vld[i] = w_tok[i+1].vld;
    end

    // Token leaving the row: matched substitute or the block unchanged
    assign w_load = (r_state == ST_SEARCH) && w_tok[TABLE_ENTRIES].vld;
    assign w_res  = w_tok[TABLE_ENTRIES].found ? w_tok[TABLE_ENTRIES].res
                                               : w_tok[TABLE_ENTRIES].blk;

    psc_ser u_ser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_load),
        .i_res         (w_res),
        .i_n           (w_tok[TABLE_ENTRIES].n),
        .o_busy        (w_ser_busy),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (w_start) n_state = ST_SEARCH;
            ST_SEARCH: if (w_load) n_state = ST_EMIT;
            ST_EMIT:   if (!w_ser_busy) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);

    // Checks
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while a run is being emitted");

    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok_vld))
        else $error("more than one lookup token in the cell row");

    a_tok_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok[TABLE_ENTRIES].vld |-> (r_state == ST_SEARCH))
        else $error("lookup token left the row outside of search");

    a_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> (r_state == ST_SEARCH) && (r_cnt == '0))
        else $error("lookup launch did not clear the gather state");

endmodule

FILE: design/psc_cell.sv
module psc_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_direction,
    input  logic            i_wr_en,
    input  psc_pkg::t_entry i_wr,
    input  psc_pkg::t_tok   i_tok,
    output psc_pkg::t_tok   o_tok
);
    import psc_pkg::*;

    logic [BLK_W-1:0] r_plain;
    logic [BLK_W-1:0] r_cipher;
    logic [LEN_W-1:0] r_len;
    logic             r_valid;
    t_tok             r_tok;
    t_tok             n_tok;

    logic [BLK_W-1:0] w_mask;
    logic [BLK_W-1:0] w_key;
    logic [BLK_W-1:0] w_sub;
    logic             w_hit;

    // Slot contents: payload has no reset, only the valid mark
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_wr_en) begin
            r_valid <= i_wr.valid;
        end
        if (i_wr_en) begin
            r_plain  <= i_wr.plain;
            r_cipher <= i_wr.cipher;
            r_len    <= i_wr.len;
        end
    end

    // Compare the passing block against this slot
    always_comb begin
        w_mask = byte_mask(i_tok.n);
        w_key  = i_direction ? r_cipher : r_plain;
        w_sub  = i_direction ? r_plain  : r_cipher;
        w_hit  = i_tok.vld && !i_tok.found && r_valid
              && (r_len == LEN_W'(i_tok.n))
              && ((w_key & w_mask) == i_tok.blk);
        n_tok  = i_tok;
        if (w_hit) begin
            n_tok.found = 1'b1;
            n_tok.res   = w_sub & w_mask;
        end
    end

    // Hand the token to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else begin
            r_tok.vld <= n_tok.vld;
        end
        r_tok.blk   <= n_tok.blk;
        r_tok.n     <= n_tok.n;
        r_tok.found <= n_tok.found;
        r_tok.res   <= n_tok.res;
    end

    assign o_tok = r_tok;

endmodule

FILE: design/psc_ser.sv
module psc_ser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic [psc_pkg::BLK_W-1:0]   i_res,
    input  logic [psc_pkg::CNT_W-1:0]   i_n,
    output logic                        o_busy,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [7:0]                  m_axis_tdata,   // out_byte[7:0]
    output logic                        m_axis_tlast    // last_of_run
);
    import psc_pkg::*;

    logic [BLK_W-1:0] r_res;
    logic [CNT_W-1:0] r_left;
    logic             w_take;

    assign w_take = m_axis_tvalid && m_axis_tready;

    // Byte count left in the current run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (i_load) begin
            r_left <= i_n;
        end else if (w_take) begin
            r_left <= r_left - CNT_W'(1);
        end
    end

    // Result bytes, lowest first
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end else if (w_take) begin
            r_res <= r_res >> 8;
        end
    end

    assign o_busy        = (r_left != '0);
    assign m_axis_tvalid = (r_left != '0);
    assign m_axis_tdata  = r_res[7:0];
    assign m_axis_tlast  = (r_left == CNT_W'(1));

endmodule

FILE: tb/polygram_substitution_cipher_checker.sv
`timescale 1ns / 100ps

// Watches the text stream, the table writes and the config port, keeps its own
// copy of the gather state and the substitution table, and compares every
// output byte with the oldest byte still owed.
module polygram_substitution_cipher_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [87:0] i_in_data,
    input  logic [1:0]  i_in_user,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_out_data,
    input  logic        i_out_last,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [2:0]  i_cfg_data,
    output int          o_owed,
    output int          o_fail_count
);
    import psc_pkg::*;

    typedef struct packed {
        logic [7:0] txt;
        logic       last;
    } t_out_byte;

    // Mirrored configuration and block state
    logic             dir_decrypt;
    logic [2:0]       blk_len_cfg;
    logic [BLK_W-1:0] gath_buf;
    int               gath_cnt;
    t_entry           tbl [TABLE_ENTRIES];

    t_out_byte owed_q[$];
    t_out_byte head;
    int        fail_cnt;
    int        slot_idx;

    assign o_fail_count = fail_cnt;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch: %s got %0h want %0h", $time, what, got, want);
        fail_cnt++;
    endtask

    function automatic int span_of(input logic [2:0] len);
        if (len == 0) return 1;
        if (len > MAX_BLOCK) return MAX_BLOCK;
        return len;
    endfunction

    // Look the gathered block up; lowest matching slot wins, else pass through
    task automatic substitute_block();
        logic [BLK_W-1:0] mask;
        logic [BLK_W-1:0] blk;
        logic [BLK_W-1:0] res;
        logic [BLK_W-1:0] key;
        logic             hit;
        t_out_byte        ob;
        mask = (gath_cnt >= MAX_BLOCK) ? '1 : ((BLK_W'(1) << (8 * gath_cnt)) - BLK_W'(1));
        blk  = gath_buf & mask;
        res  = blk;
        hit  = 1'b0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            key = dir_decrypt ? tbl[i].cipher : tbl[i].plain;
            if (!hit && tbl[i].valid && tbl[i].len == gath_cnt && (key & mask) == blk) begin
                res = (dir_decrypt ? tbl[i].plain : tbl[i].cipher) & mask;
                hit = 1'b1;
            end
        end
        for (int b = 0; b < gath_cnt; b++) begin
            ob.txt  = res[8*b +: 8];
            ob.last = (b + 1 == gath_cnt);
            owed_q.push_back(ob);
        end
        gath_buf = '0;
        gath_cnt = 0;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dir_decrypt = 1'b0;
            blk_len_cfg = 3'd3;
            gath_buf    = '0;
            gath_cnt    = 0;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                tbl[i] = '0;
            end
            owed_q.delete();
            o_owed <= 0;
        end else begin
            // Config writes
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_DIRECTION) begin
                    dir_decrypt = i_cfg_data[0];
                end else begin
                    blk_len_cfg = i_cfg_data;
                end
            end

            // Output transaction against the oldest owed byte
            if (i_out_valid && i_out_ready) begin
                if (owed_q.size() == 0) begin
                    report_mismatch("byte with nothing owed", i_out_data, 0);
                end else begin
                    head = owed_q.pop_front();
                    if (i_out_data !== head.txt) begin
                        report_mismatch("out_byte", i_out_data, head.txt);
                    end
                    if (i_out_last !== head.last) begin
                        report_mismatch("last_of_run", i_out_last, head.last);
                    end
                end
            end

            // Input transaction
            if (i_in_valid && i_in_ready) begin
                case (i_in_user)
                    MODE_TEXT: begin
                        if (gath_cnt < MAX_BLOCK) begin
                            gath_buf[8*gath_cnt +: 8] = i_in_data[7:0];
                            gath_cnt++;
                        end
                        if (gath_cnt >= span_of(blk_len_cfg)) begin
                            substitute_block();
                        end
                    end
                    MODE_FLUSH: begin
                        if (gath_cnt != 0) begin
                            substitute_block();
                        end
                    end
                    MODE_WRITE: begin
                        slot_idx = i_in_data[13:8];
                        tbl[slot_idx].plain  = i_in_data[45:14];
                        tbl[slot_idx].cipher = i_in_data[77:46];
                        tbl[slot_idx].len    = i_in_data[80:78];
                        tbl[slot_idx].valid  = i_in_data[81];
                    end
                    default: ;
                endcase
            end
            o_owed <= owed_q.size();
        end
    end

endmodule

FILE: tb/polygram_substitution_cipher_tb.sv
`timescale 1ns / 100ps

module polygram_substitution_cipher_tb;
    import psc_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 8;
    localparam int RANDOM_ITEMS  = 104;
    localparam int CYCLE_LIMIT   = 200000;

    // Item fields below the tdata zero padding, lowest first at the bottom
    typedef struct packed {
        logic        valid;
        logic [2:0]  len;
        logic [31:0] cipher;
        logic [31:0] plain;
        logic [5:0]  idx;
        logic [7:0]  txt;
    } t_item_fields;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [2:0]  i_cfg_data;

    int owed;
    int fail_count;
    int cycle_cnt = 0;

    // Stimulus-side view of the table and settings, used to build hitting blocks
    t_entry     tb_tab [TABLE_ENTRIES];
    logic       cur_dir;
    logic [2:0] cur_len;
    int         held;
    int         items_sent;
    logic       gaps_on;
    logic       stalls_on;
    int         hold_ticket;

    polygram_substitution_cipher dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    polygram_substitution_cipher_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_user    (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_last   (m_axis_tlast),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_owed       (owed),
        .o_fail_count (fail_count)
    );

    // Clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: random stall bursts, ready runs, and a long hold-off on request
    initial begin
        int stall_left;
        int run_left;
        int hold_left;
        int hold_seen;
        stall_left = 0;
        run_left   = 0;
        hold_left  = 0;
        hold_seen  = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_ticket != hold_seen) begin
                hold_seen = hold_ticket;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (run_left > 0 || !stalls_on || $urandom_range(0, 5) != 0) begin
                if (run_left > 0) run_left--;
                m_axis_tready <= 1'b1;
            end else begin
                stall_left = $urandom_range(1, 12) - 1;
                run_left   = $urandom_range(0, 30);
                m_axis_tready <= 1'b0;
            end
        end
    end

    function automatic t_item_fields rand_fields();
        logic [95:0] r;
        r = {$urandom(), $urandom(), $urandom()};
        return r[81:0];
    endfunction

    function automatic int span_of(input logic [2:0] len);
        if (len == 0) return 1;
        if (len > MAX_BLOCK) return MAX_BLOCK;
        return len;
    endfunction

    // One transaction on the text stream, with an optional gap first
    task automatic push_item(input logic [1:0] mode, input t_item_fields f);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, f};
        s_axis_tuser  <= mode;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (mode != MODE_UNUSED) items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        t_item_fields f;
        f = rand_fields();
        f.txt = b;
        push_item(MODE_TEXT, f);
        held++;
        if (held >= span_of(cur_len)) held = 0;
    endtask

    task automatic flush_msg();
        push_item(MODE_FLUSH, rand_fields());
        held = 0;
    endtask

    task automatic load_slot(input int idx, input logic [31:0] plain,
                             input logic [31:0] cipher, input logic [2:0] len,
                             input logic valid);
        t_item_fields f;
        f = rand_fields();
        f.idx    = 6'(idx);
        f.plain  = plain;
        f.cipher = cipher;
        f.len    = len;
        f.valid  = valid;
        push_item(MODE_WRITE, f);
        tb_tab[idx].plain  = plain;
        tb_tab[idx].cipher = cipher;
        tb_tab[idx].len    = len;
        tb_tab[idx].valid  = valid;
    endtask

    // Mostly lengths that can match; now and then one that never does
    task automatic load_random_slot();
        logic [2:0] len;
        len = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(1, 4))
                                         : 3'($urandom_range(0, 7));
        load_slot($urandom_range(0, TABLE_ENTRIES - 1), $urandom(), $urandom(), len,
                  $urandom_range(0, 9) != 0);
    endtask

    // Send the lookup key of a slot as a block of its own
    task automatic send_block_for_slot(input int s);
        logic [31:0] key;
        if (held != 0) flush_msg();
        key = cur_dir ? tb_tab[s].cipher : tb_tab[s].plain;
        for (int b = 0; b < tb_tab[s].len; b++) begin
            send_byte(key[8*b +: 8]);
        end
        if (held != 0) flush_msg();
    endtask

    task automatic set_mode(input logic dir, input logic [2:0] len);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_DIRECTION;
        i_cfg_data <= {2'b00, dir};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_BLOCK_LEN;
        i_cfg_data <= len;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_dir = dir;
        cur_len = len;
    endtask

    // Stop sending and wait until every owed byte is out and the block is idle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (owed != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Stimulus
    initial begin
        logic [2:0] len_plan [6];
        int rnd_start;
        int phase;
        int pick;
        int found;
        int base;
        int s;
        len_plan = '{3'd1, 3'd0, 3'd4, 3'd7, 3'd2, 3'd5};
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            tb_tab[i] = '0;
        end
        cur_dir     = 1'b0;
        cur_len     = 3'd3;
        held        = 0;
        items_sent  = 0;
        gaps_on     = 1'b1;
        stalls_on   = 1'b1;
        hold_ticket = 0;

        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= MODE_TEXT;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_DIRECTION;
        i_cfg_data    <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset settings (encrypt, 3-byte blocks)
        load_slot(0, 32'h00636261, 32'h11223344, 3'd3, 1'b1);
        load_slot(7, 32'h00636261, 32'h55667788, 3'd3, 1'b1);   // same key, loses to slot 0
        load_slot(63, 32'hFFFFFFFF, 32'h00000000, 3'd4, 1'b1);
        load_slot(9, 32'h00000000, 32'hA5A5A5A5, 3'd0, 1'b1);   // zero length, never hits
        load_slot(10, 32'h00000000, 32'h5A5A5A5A, 3'd7, 1'b1);  // too long, never hits
        send_block_for_slot(0);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h61);
        flush_msg();                                            // partial block
        flush_msg();                                            // nothing gathered
        push_item(MODE_UNUSED, rand_fields());
        load_slot(0, 32'h00636261, 32'h11223344, 3'd3, 1'b0);   // clear slot 0
        send_block_for_slot(7);
        drain();

        // Full-width block hitting the top slot, then a length drop mid-block
        set_mode(1'b0, 3'd4);
        send_block_for_slot(63);
        repeat (3) send_byte(8'h00);
        drain();
        set_mode(1'b1, 3'd2);
        send_byte(8'h00);                                       // emits all four bytes
        drain();

        // Random phases
        rnd_start = items_sent;
        phase = 0;
        while (items_sent - rnd_start < RANDOM_ITEMS) begin
            if (phase < 6) begin
                set_mode(phase[0], len_plan[phase]);
            end else begin
                set_mode(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
            end
            if (phase == 0) begin
                hold_ticket <= hold_ticket + 1;
            end
            repeat ($urandom_range(2, 5)) load_random_slot();
            repeat ($urandom_range(18, 26)) begin
                if (items_sent - rnd_start >= RANDOM_ITEMS) break;
                if (items_sent - rnd_start >= RANDOM_ITEMS - 30) begin
                    gaps_on   = 1'b0;
                    stalls_on = 1'b0;
                end
                pick = $urandom_range(0, 99);
                if (pick < 65) begin
                    found = -1;
                    base  = $urandom_range(0, TABLE_ENTRIES - 1);
                    for (int k = 0; k < TABLE_ENTRIES; k++) begin
                        s = (base + k) % TABLE_ENTRIES;
                        if (found < 0 && tb_tab[s].valid && tb_tab[s].len >= 1 &&
                            tb_tab[s].len <= span_of(cur_len)) begin
                            found = s;
                        end
                    end
                    if (found >= 0) begin
                        send_block_for_slot(found);
                    end else begin
                        send_byte(8'($urandom_range(0, 255)));
                    end
                end else if (pick < 85) begin
                    send_byte(8'($urandom_range(0, 255)));
                end else if (pick < 92) begin
                    flush_msg();
                end else if (pick < 97) begin
                    load_random_slot();
                end else begin
                    push_item(MODE_UNUSED, rand_fields());
                end
            end
            drain();
            phase++;
        end

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
